>>> hw/rtl/gzhp_pkg.sv
`default_nettype none
package gzhp_pkg;

	// Parser phases: the header parts, then payload and error
	typedef enum logic [3:0] {
		PH_ID1     = 4'd0,
		PH_ID2     = 4'd1,
		PH_CM      = 4'd2,
		PH_FLG     = 4'd3,
		PH_FIXED   = 4'd4,
		PH_XLEN0   = 4'd5,
		PH_XLEN1   = 4'd6,
		PH_EXTRA   = 4'd7,
		PH_NAME    = 4'd8,
		PH_COMMENT = 4'd9,
		PH_HCRC0   = 4'd10,
		PH_HCRC1   = 4'd11,
		PH_PAYLOAD = 4'd12,
		PH_ERROR   = 4'd13
	} phase_t;

	// Field tags on each output byte
	localparam logic [2:0] KIND_FIXED   = 3'd0;
	localparam logic [2:0] KIND_XLEN    = 3'd1;
	localparam logic [2:0] KIND_EXTRA   = 3'd2;
	localparam logic [2:0] KIND_NAME    = 3'd3;
	localparam logic [2:0] KIND_COMMENT = 3'd4;
	localparam logic [2:0] KIND_HCRC    = 3'd5;
	localparam logic [2:0] KIND_PAYLOAD = 3'd6;
	localparam logic [2:0] KIND_DISCARD = 3'd7;

	// Status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BAD_ID   = 3'd2;
	localparam logic [2:0] ST_BAD_CM   = 3'd3;
	localparam logic [2:0] ST_BAD_HCRC = 3'd4;

	// Stages after which the optional parts are chosen
	localparam logic [1:0] AFTER_FIXED   = 2'd0;
	localparam logic [1:0] AFTER_EXTRA   = 2'd1;
	localparam logic [1:0] AFTER_NAME    = 2'd2;
	localparam logic [1:0] AFTER_COMMENT = 2'd3;

	// Header constants
	localparam logic [7:0]  ID1_BYTE   = 8'h1f;
	localparam logic [7:0]  ID2_BYTE   = 8'h8b;
	localparam logic [7:0]  CM_DEFLATE = 8'h08;
	localparam logic [15:0] FIXED_LEN  = 16'd10;
	localparam logic [15:0] FLG_COUNT  = 16'd4;
	localparam logic [31:0] CRC_PRESET = 32'hffff_ffff;
	localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;

	localparam int FLAG_HCRC    = 1;
	localparam int FLAG_EXTRA   = 2;
	localparam int FLAG_NAME    = 3;
	localparam int FLAG_COMMENT = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_req;
	} stream_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_kind;
		logic [2:0] status;
		logic [7:0] header_flags;
	} token_t;

	typedef struct packed {
		phase_t phase;
		logic   done;
	} step_t;

	// Reflected CRC-32 update over one byte
	function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

	// Pick the next optional part present in the flags
	function automatic step_t go_next(input logic [1:0] stage, input logic [7:0] flags);
		step_t s;
		s.done  = 1'b0;
		s.phase = PH_PAYLOAD;
		if (stage < AFTER_EXTRA && flags[FLAG_EXTRA]) begin
			s.phase = PH_XLEN0;
		end else if (stage < AFTER_NAME && flags[FLAG_NAME]) begin
			s.phase = PH_NAME;
		end else if (stage < AFTER_COMMENT && flags[FLAG_COMMENT]) begin
			s.phase = PH_COMMENT;
		end else if (flags[FLAG_HCRC]) begin
			s.phase = PH_HCRC0;
		end else begin
			s.phase = PH_PAYLOAD;
			s.done  = 1'b1;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gzip_header_parser_core.sv
// gzip member header parser.
// Feed the stream one byte per transaction on the stream channel
// (stream_valid / stream_stall / stream). Set start_req on the ID1 byte of
// a new member; it clears all parser state first. Each accepted byte yields
// exactly one transaction on the token channel (token_valid / token_stall /
// token): the byte itself, a tag naming its header field, a status code and
// the latched FLG byte.
// The token is registered: it appears in the output register on the cycle
// after the byte is accepted. Throughput is one byte per cycle while the
// receiver does not stall, set by the byte-wide CRC-32 update and the
// phase decode between the input and the output register.
// Reset leaves the output register empty and the parser expecting ID1.
// While the receiver stalls, the token holds; stream_stall is raised while
// the output register is full and stalled, so no byte is dropped.
// Errors are sticky: later bytes come out tagged as discarded with the
// error status until the next start_req.
`default_nettype none
module gzip_header_parser_core import gzhp_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     stream_valid,
	output logic    stream_stall,
	input  stream_t stream,
	output logic    token_valid,
	input  wire     token_stall,
	output token_t  token
);

	phase_t      phase_q;
	logic [15:0] count_q;
	logic [7:0]  flag_q;
	logic [7:0]  len_low_q;
	logic [31:0] crc_q;
	logic [7:0]  crc_low_q;
	logic [2:0]  err_q;

	phase_t      phase_cur, phase_nxt;
	logic [15:0] count_cur, count_nxt;
	logic [7:0]  flag_cur, flag_nxt;
	logic [7:0]  len_low_nxt;
	logic [31:0] crc_cur, crc_nxt;
	logic [7:0]  crc_low_cur, crc_low_nxt;
	logic [2:0]  err_cur, err_nxt;
	logic [15:0] count_inc, count_dec, xlen;
	logic [7:0]  b;
	logic        hcrc_ok;
	logic        done;
	logic [2:0]  kind;
	logic [2:0]  status;
	step_t       step;
	logic        accept;
	token_t      token_q;
	logic        token_valid_q;

	assign accept       = stream_valid && !stream_stall;
	assign stream_stall = token_valid_q && token_stall;
	assign b            = stream.in_byte;

	// Start request takes the reset state for this byte
	always_comb begin
		if (stream.start_req) begin
			phase_cur   = PH_ID1;
			count_cur   = '0;
			flag_cur    = '0;
			crc_cur     = CRC_PRESET;
			crc_low_cur = '0;
			err_cur     = ST_BUSY;
		end else begin
			phase_cur   = phase_q;
			count_cur   = count_q;
			flag_cur    = flag_q;
			crc_cur     = crc_q;
			crc_low_cur = crc_low_q;
			err_cur     = err_q;
		end
	end

	assign count_inc = count_cur + 16'd1;
	assign count_dec = count_cur - 16'd1;
	assign xlen      = {b, len_low_q};
	assign hcrc_ok   = (~crc_cur[15:0]) == {b, crc_low_cur};

	// Next state
	always_comb begin
		phase_nxt   = phase_cur;
		count_nxt   = count_cur;
		flag_nxt    = flag_cur;
		len_low_nxt = len_low_q;
		crc_low_nxt = crc_low_cur;
		err_nxt     = err_cur;
		done        = 1'b0;
		step        = go_next(AFTER_FIXED, flag_cur);
		crc_nxt     = (phase_cur < PH_HCRC0) ? crc_update(crc_cur, b) : crc_cur;
		if (stream.start_req) begin
			len_low_nxt = '0;
		end
		unique case (phase_cur)
			PH_ID1: begin
				if (b != ID1_BYTE) begin
					phase_nxt = PH_ERROR;
					err_nxt   = ST_BAD_ID;
				end else begin
					phase_nxt = PH_ID2;
				end
			end
			PH_ID2: begin
				if (b != ID2_BYTE) begin
					phase_nxt = PH_ERROR;
					err_nxt   = ST_BAD_ID;
				end else begin
					phase_nxt = PH_CM;
				end
			end
			PH_CM: begin
				if (b != CM_DEFLATE) begin
					phase_nxt = PH_ERROR;
					err_nxt   = ST_BAD_CM;
				end else begin
					phase_nxt = PH_FLG;
				end
			end
			PH_FLG: begin
				flag_nxt  = b;
				count_nxt = FLG_COUNT;
				phase_nxt = PH_FIXED;
			end
			PH_FIXED: begin
				count_nxt = count_inc;
				if (count_inc >= FIXED_LEN) begin
					step      = go_next(AFTER_FIXED, flag_cur);
					phase_nxt = step.phase;
					done      = step.done;
				end
			end
			PH_XLEN0: begin
				len_low_nxt = b;
				phase_nxt   = PH_XLEN1;
			end
			PH_XLEN1: begin
				count_nxt = xlen;
				if (xlen == 16'd0) begin
					step      = go_next(AFTER_EXTRA, flag_cur);
					phase_nxt = step.phase;
					done      = step.done;
				end else begin
					phase_nxt = PH_EXTRA;
				end
			end
			PH_EXTRA: begin
				count_nxt = count_dec;
				if (count_dec == 16'd0) begin
					step      = go_next(AFTER_EXTRA, flag_cur);
					phase_nxt = step.phase;
					done      = step.done;
				end
			end
			PH_NAME: begin
				if (b == 8'd0) begin
					step      = go_next(AFTER_NAME, flag_cur);
					phase_nxt = step.phase;
					done      = step.done;
				end
			end
			PH_COMMENT: begin
				if (b == 8'd0) begin
					step      = go_next(AFTER_COMMENT, flag_cur);
					phase_nxt = step.phase;
					done      = step.done;
				end
			end
			PH_HCRC0: begin
				crc_low_nxt = b;
				phase_nxt   = PH_HCRC1;
			end
			PH_HCRC1: begin
				if (hcrc_ok) begin
					phase_nxt = PH_PAYLOAD;
					done      = 1'b1;
				end else begin
					phase_nxt = PH_ERROR;
					err_nxt   = ST_BAD_HCRC;
				end
			end
			PH_PAYLOAD: begin
				phase_nxt = PH_PAYLOAD;
			end
			default: begin
				phase_nxt = PH_ERROR;
			end
		endcase
	end

	// Outputs: field tag and status for this byte
	always_comb begin
		kind   = KIND_FIXED;
		status = done ? ST_DONE : ST_BUSY;
		unique case (phase_cur) inside
			PH_ID1, PH_ID2, PH_CM: begin
				kind   = KIND_FIXED;
				status = err_nxt;
			end
			PH_FLG, PH_FIXED: kind = KIND_FIXED;
			PH_XLEN0, PH_XLEN1: kind = KIND_XLEN;
			PH_EXTRA: kind = KIND_EXTRA;
			PH_NAME: kind = KIND_NAME;
			PH_COMMENT: kind = KIND_COMMENT;
			PH_HCRC0: kind = KIND_HCRC;
			PH_HCRC1: begin
				kind   = KIND_HCRC;
				status = hcrc_ok ? ST_DONE : ST_BAD_HCRC;
			end
			PH_PAYLOAD: begin
				kind   = KIND_PAYLOAD;
				status = ST_BUSY;
			end
			default: begin
				kind   = KIND_DISCARD;
				status = err_cur;
			end
		endcase
	end

	// Advance parser state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID1;
			count_q   <= '0;
			flag_q    <= '0;
			len_low_q <= '0;
			crc_q     <= CRC_PRESET;
			crc_low_q <= '0;
			err_q     <= ST_BUSY;
		end else if (accept) begin
			phase_q   <= phase_nxt;
			count_q   <= count_nxt;
			flag_q    <= flag_nxt;
			len_low_q <= len_low_nxt;
			crc_q     <= crc_nxt;
			crc_low_q <= crc_low_nxt;
			err_q     <= err_nxt;
		end
	end

	// Hold the token while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else if (accept) begin
			token_valid_q <= 1'b1;
		end else if (!token_stall) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			token_q.out_byte     <= b;
			token_q.field_kind   <= kind;
			token_q.status       <= status;
			token_q.header_flags <= flag_nxt;
		end
	end

	assign token_valid = token_valid_q;
	assign token       = token_q;

	// Every accepted byte lands in the output register
	a_accept_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> token_valid)
		else $error("accepted byte produced no token");

	// Parser state moves only on an accepted transaction
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(crc_q) && $stable(count_q))
		else $error("parser state changed without a transaction");

	// Payload is reached only on an error-free header
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> err_q == ST_BUSY)
		else $error("payload phase with sticky error");

	// Discarded bytes always carry an error status
	a_discard_status: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.field_kind == KIND_DISCARD |->
			token.status == ST_BAD_ID || token.status == ST_BAD_CM ||
			token.status == ST_BAD_HCRC)
		else $error("discarded byte without error status");

	// Error phase always holds a sticky error code
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> err_q != ST_BUSY)
		else $error("error phase without error code");

endmodule
`default_nettype wire

>>> test/gzip_header_parser_core_test.sv
`timescale 1ns / 100ps
module gzip_header_parser_core_test import gzhp_pkg::*; ;

	// How a script byte is filled in: as written, or from the running header CRC
	typedef enum logic [1:0] {
		FILL_NONE   = 2'd0,
		FILL_CRC_LO = 2'd1,
		FILL_CRC_HI = 2'd2
	} fill_t;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
		fill_t      fill;
		logic       typed;
		token_t     want;
	} script_row_t;

	typedef struct packed {
		stream_t item;
		logic    typed;
		token_t  want;
	} feed_t;

	localparam int     SCRIPT_LEN   = 22;
	localparam int     RANDOM_ITEMS = 1700;
	localparam int     IDLE_LIMIT   = 2000;
	localparam int     HOLD_AT      = 300;
	localparam int     HOLD_CYCLES  = 250;
	localparam int     STEADY_FROM  = 700;
	localparam int     STEADY_TO    = 1000;
	localparam token_t NO_TOKEN     = '0;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    stream_valid;
	logic    stream_stall;
	stream_t stream;
	logic    token_valid;
	logic    token_stall;
	token_t  token;

	// Parser state as predicted
	phase_t      hdr_phase;
	logic [15:0] run_count;
	logic [7:0]  flg_q;
	logic [7:0]  xlen_lo;
	logic [31:0] hdr_crc;
	logic [7:0]  hcrc_lo;
	logic [2:0]  sticky_err;

	token_t      token_q[$];
	feed_t       feed_q[$];
	feed_t       cur_feed = '0;
	script_row_t script [SCRIPT_LEN];

	int   n_fail      = 0;
	int   n_fed       = 0;
	int   n_tokens    = 0;
	int   n_complete  = 0;
	int   n_rejects   = 0;
	int   quiet_count = 0;
	logic no_idle;

	assign no_idle = (n_fed >= STEADY_FROM) && (n_fed < STEADY_TO);

	gzip_header_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream       (stream),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token        (token)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		repeat (8) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic void clear_parser();
		hdr_phase  = PH_ID1;
		run_count  = '0;
		flg_q      = '0;
		xlen_lo    = '0;
		hdr_crc    = CRC_PRESET;
		hcrc_lo    = '0;
		sticky_err = ST_BUSY;
	endfunction

	function automatic logic [2:0] raise_error(input logic [2:0] code);
		sticky_err = code;
		hdr_phase  = PH_ERROR;
		return code;
	endfunction

	// Move to the next optional part that FLG asks for; report completion
	function automatic logic [2:0] advance_part(input logic [1:0] stage);
		if (stage < AFTER_EXTRA && flg_q[FLAG_EXTRA]) begin
			hdr_phase = PH_XLEN0;
		end else if (stage < AFTER_NAME && flg_q[FLAG_NAME]) begin
			hdr_phase = PH_NAME;
		end else if (stage < AFTER_COMMENT && flg_q[FLAG_COMMENT]) begin
			hdr_phase = PH_COMMENT;
		end else if (flg_q[FLAG_HCRC]) begin
			hdr_phase = PH_HCRC0;
		end else begin
			hdr_phase = PH_PAYLOAD;
			return ST_DONE;
		end
		return ST_BUSY;
	endfunction

	// Predict the token for one stream byte and advance the parser state
	function automatic token_t parse_byte(input stream_t s);
		logic [7:0] b;
		logic [2:0] kind;
		logic [2:0] stat;
		b    = s.in_byte;
		kind = KIND_FIXED;
		stat = ST_BUSY;
		if (s.start_req)
			clear_parser();
		if (hdr_phase < PH_HCRC0)
			hdr_crc = crc32_byte(hdr_crc, b);
		case (hdr_phase)
			PH_ID1: begin
				if (b != ID1_BYTE) stat = raise_error(ST_BAD_ID);
				else hdr_phase = PH_ID2;
			end
			PH_ID2: begin
				if (b != ID2_BYTE) stat = raise_error(ST_BAD_ID);
				else hdr_phase = PH_CM;
			end
			PH_CM: begin
				if (b != CM_DEFLATE) stat = raise_error(ST_BAD_CM);
				else hdr_phase = PH_FLG;
			end
			PH_FLG: begin
				flg_q     = b;
				run_count = FLG_COUNT;
				hdr_phase = PH_FIXED;
			end
			PH_FIXED: begin
				run_count = run_count + 16'd1;
				if (run_count >= FIXED_LEN)
					stat = advance_part(AFTER_FIXED);
			end
			PH_XLEN0: begin
				kind      = KIND_XLEN;
				xlen_lo   = b;
				hdr_phase = PH_XLEN1;
			end
			PH_XLEN1: begin
				kind      = KIND_XLEN;
				run_count = {b, xlen_lo};
				if (run_count == 16'd0) stat = advance_part(AFTER_EXTRA);
				else hdr_phase = PH_EXTRA;
			end
			PH_EXTRA: begin
				kind      = KIND_EXTRA;
				run_count = run_count - 16'd1;
				if (run_count == 16'd0)
					stat = advance_part(AFTER_EXTRA);
			end
			PH_NAME: begin
				kind = KIND_NAME;
				if (b == 8'd0)
					stat = advance_part(AFTER_NAME);
			end
			PH_COMMENT: begin
				kind = KIND_COMMENT;
				if (b == 8'd0)
					stat = advance_part(AFTER_COMMENT);
			end
			PH_HCRC0: begin
				kind      = KIND_HCRC;
				hcrc_lo   = b;
				hdr_phase = PH_HCRC1;
			end
			PH_HCRC1: begin
				kind = KIND_HCRC;
				if ((~hdr_crc[15:0]) == {b, hcrc_lo}) begin
					hdr_phase = PH_PAYLOAD;
					stat      = ST_DONE;
				end else begin
					stat = raise_error(ST_BAD_HCRC);
				end
			end
			PH_PAYLOAD: begin
				kind = KIND_PAYLOAD;
			end
			default: begin
				kind = KIND_DISCARD;
				stat = sticky_err;
			end
		endcase
		return {b, kind, stat, flg_q};
	endfunction

	// Queue one gzip member: mostly well formed, some broken or cut short
	task automatic queue_member();
		logic [7:0]  hdr[$];
		logic [31:0] crc;
		logic [7:0]  flg;
		feed_t       rec;
		int          roll;
		int          xlen;
		int          cut;
		int          k;
		roll = $urandom_range(0, 99);
		flg  = 8'($urandom_range(0, 255));
		hdr  = {ID1_BYTE, ID2_BYTE, CM_DEFLATE, flg};
		repeat (6) hdr = {hdr, 8'($urandom_range(0, 255))};
		if (flg[FLAG_EXTRA]) begin
			xlen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
			hdr = {hdr, xlen[7:0]};
			hdr = {hdr, xlen[15:8]};
			repeat (xlen) hdr = {hdr, 8'($urandom_range(0, 255))};
		end
		if (flg[FLAG_NAME]) begin
			repeat ($urandom_range(0, 6)) hdr = {hdr, 8'($urandom_range(1, 255))};
			hdr = {hdr, 8'd0};
		end
		if (flg[FLAG_COMMENT]) begin
			repeat ($urandom_range(0, 6)) hdr = {hdr, 8'($urandom_range(1, 255))};
			hdr = {hdr, 8'd0};
		end
		if (flg[FLAG_HCRC]) begin
			crc = CRC_PRESET;
			foreach (hdr[i])
				crc = crc32_byte(crc, hdr[i]);
			crc = ~crc;
			if (roll < 10)
				crc = crc ^ (32'd1 << $urandom_range(0, 15));
			hdr = {hdr, crc[7:0]};
			hdr = {hdr, crc[15:8]};
		end
		// break an ID or CM byte
		if (roll >= 10 && roll < 20) begin
			k      = $urandom_range(0, 2);
			hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
		end
		// cut the header short; the next start restarts it
		if (roll >= 20 && roll < 28) begin
			cut = $urandom_range(1, hdr.size() - 1);
			while (hdr.size() > cut)
				void'(hdr.pop_back());
		end
		// stray bytes ahead of the member, the first one maybe a false start
		if (roll >= 28 && roll < 33) begin
			rec = '0;
			repeat ($urandom_range(1, 4)) begin
				rec.item.in_byte   = 8'($urandom_range(0, 255));
				rec.item.start_req = 1'($urandom_range(0, 1));
				feed_q = {feed_q, rec};
				rec.item.start_req = 1'b0;
			end
		end
		rec = '0;
		foreach (hdr[i]) begin
			rec.item.in_byte   = hdr[i];
			rec.item.start_req = (i == 0);
			feed_q = {feed_q, rec};
		end
		rec = '0;
		repeat ($urandom_range(0, 8)) begin
			rec.item.in_byte = 8'($urandom_range(0, 255));
			feed_q = {feed_q, rec};
		end
	endtask

	task automatic compare_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			n_fail++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
		end
	endtask

	// Predict on each accepted byte, check each accepted token
	always @(posedge clk) begin : track
		token_t guess;
		token_t want;
		if (!arst_n) begin
			clear_parser();
		end else begin
			if (stream_valid && !stream_stall) begin
				guess = parse_byte(stream);
				want  = cur_feed.typed ? cur_feed.want : guess;
				if (want.status == ST_DONE)
					n_complete++;
				else if (want.status != ST_BUSY && want.field_kind != KIND_DISCARD)
					n_rejects++;
				token_q = {token_q, want};
				n_fed++;
			end
			if (token_valid && !token_stall) begin
				n_tokens++;
				if (token_q.size() == 0) begin
					n_fail++;
					$display("%0t: token %h with nothing expected", $time, token);
				end else begin
					want = token_q.pop_front();
					compare_field("out_byte", want.out_byte, token.out_byte);
					compare_field("field_kind", 8'(want.field_kind), 8'(token.field_kind));
					compare_field("status", 8'(want.status), 8'(token.status));
					compare_field("header_flags", want.header_flags, token.header_flags);
				end
			end
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (stream_valid && !stream_stall) || (token_valid && !token_stall))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d tokens still due",
				$time, IDLE_LIMIT, token_q.size());
			$display("gzip_header_parser_core_test: errors");
			$finish;
		end
	end

	// Token receiver: random stalls, one long hold-off, one stretch without stalls
	initial begin : drain
		int hold_left;
		bit held;
		hold_left   = 0;
		held        = 1'b0;
		token_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_fed >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_stall <= 1'b1;
			end else begin
				token_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 33);
			end
		end
	end

	// Byte sender: directed script, then random members
	initial begin : feed
		script_row_t row;
		feed_t       rec;
		logic [31:0] run_crc;
		stream_valid = 1'b0;
		stream       = '0;

		script = '{
			// no start: reset already expects ID1, and zero is no ID1
			'{1'b0, 8'h00, FILL_NONE, 1'b1, {8'h00, KIND_FIXED,   ST_BAD_ID, 8'h00}},
			'{1'b0, 8'hff, FILL_NONE, 1'b1, {8'hff, KIND_DISCARD, ST_BAD_ID, 8'h00}},
			// restart, then a method other than deflate
			'{1'b1, 8'h1f, FILL_NONE, 1'b1, {8'h1f, KIND_FIXED,   ST_BUSY,   8'h00}},
			'{1'b0, 8'h8b, FILL_NONE, 1'b1, {8'h8b, KIND_FIXED,   ST_BUSY,   8'h00}},
			'{1'b0, 8'h07, FILL_NONE, 1'b1, {8'h07, KIND_FIXED,   ST_BAD_CM, 8'h00}},
			// every flag set, reserved bits too; zero XLEN, empty name and comment
			'{1'b1, 8'h1f, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h8b, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h08, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'hff, FILL_NONE, 1'b1, {8'hff, KIND_FIXED,   ST_BUSY,   8'hff}},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'hff, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h5a, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'ha5, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'hff, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_NONE, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_CRC_LO, 1'b0, NO_TOKEN},
			'{1'b0, 8'h00, FILL_CRC_HI, 1'b0, NO_TOKEN},
			'{1'b0, 8'h3c, FILL_NONE, 1'b1, {8'h3c, KIND_PAYLOAD, ST_BUSY,   8'hff}}
		};

		// Fill in header CRC bytes from the bytes since the last start
		run_crc = CRC_PRESET;
		foreach (script[i]) begin
			row = script[i];
			if (row.start)
				run_crc = CRC_PRESET;
			case (row.fill)
				FILL_CRC_LO: row.data = ~run_crc[7:0];
				FILL_CRC_HI: row.data = ~run_crc[15:8];
				default:     run_crc  = crc32_byte(run_crc, row.data);
			endcase
			rec.item.in_byte   = row.data;
			rec.item.start_req = row.start;
			rec.typed          = row.typed;
			rec.want           = row.want;
			feed_q = {feed_q, rec};
		end
		while (feed_q.size() < SCRIPT_LEN + RANDOM_ITEMS)
			queue_member();

		@(posedge arst_n);
		while (feed_q.size() != 0) begin
			rec = feed_q.pop_front();
			@(negedge clk);
			while (!no_idle && $urandom_range(0, 99) < 33) begin
				stream_valid <= 1'b0;
				@(negedge clk);
			end
			cur_feed     = rec;
			stream       <= rec.item;
			stream_valid <= 1'b1;
			// hold the transaction until it is taken
			do @(posedge clk); while (stream_stall);
		end
		@(negedge clk);
		stream_valid <= 1'b0;

		// drain, then allow the output register to settle
		while (token_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("%0d bytes parsed into %0d tokens, with one long receiver hold-off",
			n_fed, n_tokens);
		$display("%0d headers completed, %0d rejected for bad ID, method or header CRC",
			n_complete, n_rejects);
		if (n_fail == 0 && token_q.size() == 0)
			$display("gzip_header_parser_core_test: clean");
		else
			$display("gzip_header_parser_core_test: errors");
		$finish;
	end

endmodule
